### rtl/acr_pkg.sv
`default_nettype none

package acr_pkg;

	// Encoding of a colour spec's kind field
	typedef enum logic [1:0] {
		KIND_DEFAULT = 2'd0,
		KIND_BASIC   = 2'd1,
		KIND_INDEXED = 2'd2,
		KIND_RGB     = 2'd3
	} color_kind_t;

	// Register map: index of each register in the APB window
	localparam logic REG_DEFAULT_FG = 1'b0;
	localparam logic REG_DEFAULT_BG = 1'b1;

	localparam logic [23:0] DEFAULT_FG_RESET = 24'hFFFFFF;
	localparam logic [23:0] DEFAULT_BG_RESET = 24'h242424;

	// Cube and grey ramp constants
	localparam logic [7:0] CUBE_BASE   = 8'd16;
	localparam logic [7:0] GREY_BASE   = 8'd232;
	localparam logic [7:0] CUBE_OFFSET = 8'd55;
	localparam logic [7:0] CUBE_STEP   = 8'd40;
	localparam logic [7:0] GREY_OFFSET = 8'd8;
	localparam logic [7:0] GREY_STEP   = 8'd10;

	// 16-entry ANSI palette, packed RGB
	localparam logic [23:0] ANSI16 [16] = '{
		24'h000000, 24'h800000, 24'h008000, 24'h808000,
		24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
		24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
		24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
	};

	// Default colour registers as seen by the datapath
	typedef struct packed {
		logic [23:0] fg;
		logic [23:0] bg;
	} cfg_t;

	// Resolved spec: whether a colour was given, and the colour
	typedef struct packed {
		logic        given;
		logic [23:0] rgb;
	} spec_res_t;

	// Cube step to channel level: 0 stays 0, else 55 + 40 * step
	function automatic logic [7:0] cube_level(input logic [2:0] step);
		logic [7:0] lvl;
		lvl = CUBE_OFFSET + 8'({5'd0, step} * CUBE_STEP);
		return (step == 3'd0) ? 8'd0 : lvl;
	endfunction

endpackage

`default_nettype wire

### rtl/acr_if.sv
`default_nettype none

interface acr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  fg_kind;
	logic [7:0]  fg_index;
	logic        fg_bright;
	logic [23:0] fg_rgb;
	logic [1:0]  bg_kind;
	logic [7:0]  bg_index;
	logic        bg_bright;
	logic [23:0] bg_rgb;
	logic        inverse;
	logic        bold_in;
	logic        underline_in;

	modport source (
		output valid, fg_kind, fg_index, fg_bright, fg_rgb,
		       bg_kind, bg_index, bg_bright, bg_rgb, inverse, bold_in, underline_in,
		input  ready
	);
	modport sink (
		input  valid, fg_kind, fg_index, fg_bright, fg_rgb,
		       bg_kind, bg_index, bg_bright, bg_rgb, inverse, bold_in, underline_in,
		output ready
	);
endinterface

interface acr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] fg_red;
	logic [7:0] fg_green;
	logic [7:0] fg_blue;
	logic [7:0] bg_red;
	logic [7:0] bg_green;
	logic [7:0] bg_blue;
	logic       bg_shown;
	logic       bold_out;
	logic       underline_out;

	modport source (
		output valid, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
		       bg_shown, bold_out, underline_out,
		input  ready
	);
	modport sink (
		input  valid, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
		       bg_shown, bold_out, underline_out,
		output ready
	);
endinterface

`default_nettype wire

### rtl/ansi_style_color_resolver_core.sv
// Each input transfer is registered in the input stage, then in the result stage, which drives cell_out.
// Throughput: one cell per cycle unless stalled; the input stage refills as the result stage drains.
// Both stages stall together when cell_out is held off; cell_in.ready drops only then.
// Reset (arst_n low, asynchronous): both stages empty, foreground fallback register 0xFFFFFF,
// background fallback register 0x242424.
`default_nettype none

module ansi_style_color_resolver_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	acr_in_if.sink           cell_in,
	acr_out_if.source        cell_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	acr_pkg::cfg_t cfg;

	// Input stage
	logic        valid_s1;
	logic [1:0]  fg_kind_s1;
	logic [7:0]  fg_index_s1;
	logic        fg_bright_s1;
	logic [23:0] fg_rgb_s1;
	logic [1:0]  bg_kind_s1;
	logic [7:0]  bg_index_s1;
	logic        bg_bright_s1;
	logic [23:0] bg_rgb_s1;
	logic        inverse_s1;
	logic        bold_s1;
	logic        underline_s1;

	// Result stage
	logic        valid_s2;
	logic [23:0] fg_col_s2;
	logic [23:0] bg_col_s2;
	logic        bg_shown_s2;
	logic        bold_s2;
	logic        underline_s2;

	logic               adv_s2;
	logic               adv_s1;
	acr_pkg::spec_res_t fg_res;
	acr_pkg::spec_res_t bg_res;
	logic [23:0]        fg_col;
	logic [23:0]        bg_col;
	logic               bg_shown;

	acr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Result stage may load when empty or when its item transfers out this cycle.
	assign adv_s2 = !valid_s2 || cell_out.ready;
	// Input stage moves forward whenever the result stage can take it.
	assign adv_s1 = valid_s1 && adv_s2;
	// Take a new cell when the input stage is empty or drains now.
	assign cell_in.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cell_in.ready) begin
			valid_s1 <= cell_in.valid;
		end
	end

	// Capture payload on every input transfer; hold otherwise.
	always_ff @(posedge clk) begin
		if (cell_in.valid && cell_in.ready) begin
			fg_kind_s1   <= cell_in.fg_kind;
			fg_index_s1  <= cell_in.fg_index;
			fg_bright_s1 <= cell_in.fg_bright;
			fg_rgb_s1    <= cell_in.fg_rgb;
			bg_kind_s1   <= cell_in.bg_kind;
			bg_index_s1  <= cell_in.bg_index;
			bg_bright_s1 <= cell_in.bg_bright;
			bg_rgb_s1    <= cell_in.bg_rgb;
			inverse_s1   <= cell_in.inverse;
			bold_s1      <= cell_in.bold_in;
			underline_s1 <= cell_in.underline_in;
		end
	end

	// Resolve each color spec independently. A bad basic index falls back to the
	// default foreground even on the background side.
	acr_spec_resolve u_fg_spec (
		.kind       (fg_kind_s1),
		.index      (fg_index_s1),
		.bright     (fg_bright_s1),
		.rgb        (fg_rgb_s1),
		.default_fg (cfg.fg),
		.res        (fg_res)
	);

	acr_spec_resolve u_bg_spec (
		.kind       (bg_kind_s1),
		.index      (bg_index_s1),
		.bright     (bg_bright_s1),
		.rgb        (bg_rgb_s1),
		.default_fg (cfg.fg),
		.res        (bg_res)
	);

	// Inverse swaps the sides; a missing color comes from the default of the side
	// it came from, and under inverse the background is always filled.
	always_comb begin
		if (inverse_s1) begin
			fg_col   = bg_res.given ? bg_res.rgb : cfg.bg;
			bg_col   = fg_res.given ? fg_res.rgb : cfg.fg;
			bg_shown = 1'b1;
		end else begin
			fg_col   = fg_res.given ? fg_res.rgb : cfg.fg;
			bg_col   = bg_res.given ? bg_res.rgb : cfg.bg;
			bg_shown = bg_res.given;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fg_col_s2    <= fg_col;
			bg_col_s2    <= bg_col;
			bg_shown_s2  <= bg_shown;
			bold_s2      <= bold_s1;
			underline_s2 <= underline_s1;
		end
	end

	assign cell_out.valid         = valid_s2;
	assign cell_out.fg_red        = fg_col_s2[23:16];
	assign cell_out.fg_green      = fg_col_s2[15:8];
	assign cell_out.fg_blue       = fg_col_s2[7:0];
	assign cell_out.bg_red        = bg_col_s2[23:16];
	assign cell_out.bg_green      = bg_col_s2[15:8];
	assign cell_out.bg_blue       = bg_col_s2[7:0];
	assign cell_out.bg_shown      = bg_shown_s2;
	assign cell_out.bold_out      = bold_s2;
	assign cell_out.underline_out = underline_s2;

endmodule

`default_nettype wire

### rtl/acr_apb_regs.sv
`default_nettype none

module acr_apb_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output      logic [31:0]   prdata,
	output      logic          pready,
	output      acr_pkg::cfg_t cfg
);

	logic [23:0] default_fg_q;
	logic [23:0] default_bg_q;
	logic        wr_en;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_fg_q <= acr_pkg::DEFAULT_FG_RESET;
			default_bg_q <= acr_pkg::DEFAULT_BG_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				acr_pkg::REG_DEFAULT_FG: default_fg_q <= pwdata[23:0];
				acr_pkg::REG_DEFAULT_BG: default_bg_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			acr_pkg::REG_DEFAULT_FG: prdata = {8'd0, default_fg_q};
			acr_pkg::REG_DEFAULT_BG: prdata = {8'd0, default_bg_q};
			default:                 prdata = 32'd0;
		endcase
	end

	assign cfg.fg = default_fg_q;
	assign cfg.bg = default_bg_q;

endmodule

`default_nettype wire

### rtl/acr_spec_resolve.sv
`default_nettype none

module acr_spec_resolve (
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  index,
	input  wire logic        bright,
	input  wire logic [23:0] rgb,
	input  wire logic [23:0] default_fg,
	output acr_pkg::spec_res_t res
);

	logic [8:0]  basic_idx;
	logic [23:0] basic_rgb;
	logic [7:0]  cube_idx;
	logic [13:0] r_prod;
	logic [2:0]  r_step;
	logic [7:0]  r_base;
	logic [5:0]  rem36;
	logic [11:0] g_prod;
	logic [2:0]  g_step;
	logic [2:0]  b_step;
	logic [7:0]  grey_off;
	logic [7:0]  grey;
	logic [23:0] indexed_rgb;

	// Basic: bright adds 8, anything past the palette falls back to default fg
	assign basic_idx = {1'b0, index} + (bright ? 9'd8 : 9'd0);
	assign basic_rgb = (basic_idx[8:4] != 5'd0) ? default_fg : acr_pkg::ANSI16[basic_idx[3:0]];

	// Cube: divide by 36 and 6 via reciprocal multiply (exact over 0..215)
	assign cube_idx = index - acr_pkg::CUBE_BASE;
	assign r_prod   = {6'd0, cube_idx} * 14'd57;
	assign r_step   = r_prod[13:11];
	assign r_base   = 8'({5'd0, r_step} * 8'd36);
	assign rem36    = 6'(cube_idx - r_base);
	assign g_prod   = {6'd0, rem36} * 12'd43;
	assign g_step   = g_prod[10:8];
	assign b_step   = 3'(rem36 - 6'({3'd0, g_step} * 6'd6));

	assign grey_off = index - acr_pkg::GREY_BASE;
	assign grey     = acr_pkg::GREY_OFFSET + 8'(grey_off * acr_pkg::GREY_STEP);

	always_comb begin
		if (index < acr_pkg::CUBE_BASE) begin
			indexed_rgb = acr_pkg::ANSI16[index[3:0]];
		end else if (index >= acr_pkg::GREY_BASE) begin
			indexed_rgb = {grey, grey, grey};
		end else begin
			indexed_rgb = {acr_pkg::cube_level(r_step), acr_pkg::cube_level(g_step),
			               acr_pkg::cube_level(b_step)};
		end
	end

	always_comb begin
		case (acr_pkg::color_kind_t'(kind))
			acr_pkg::KIND_BASIC:   res = '{given: 1'b1, rgb: basic_rgb};
			acr_pkg::KIND_INDEXED: res = '{given: 1'b1, rgb: indexed_rgb};
			acr_pkg::KIND_RGB:     res = '{given: 1'b1, rgb: rgb};
			default:               res = '{given: 1'b0, rgb: 24'd0};
		endcase
	end

endmodule

`default_nettype wire

### rtl/acr_checker.sv
`default_nettype none

module acr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [23:0] out_fg,
	input wire logic        out_bold
);

	// A stalled result holds its place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_fg) && $stable(out_bold))
		else $error("result payload changed while stalled");

	// Input side backs off only when the output side is stalled.
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without output stall");

	// A new result must come from an input transfer that passed through the input stage and the result stage.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without matching input transfer");

endmodule

bind ansi_style_color_resolver_core acr_checker u_acr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cell_in.valid),
	.in_ready  (cell_in.ready),
	.out_valid (cell_out.valid),
	.out_ready (cell_out.ready),
	.out_fg    ({cell_out.fg_red, cell_out.fg_green, cell_out.fg_blue}),
	.out_bold  (cell_out.bold_out)
);

`default_nettype wire
